// ===== rtl/complex_arithmetic_unit_top_defines.svh =====
// ----------------------------------------------------------------------------
// complex_arithmetic_unit_top_defines
// assertion macros used by the complex alu top
// ----------------------------------------------------------------------------
`ifndef COMPLEX_ARITHMETIC_UNIT_TOP_DEFINES_SVH
`define COMPLEX_ARITHMETIC_UNIT_TOP_DEFINES_SVH
`ifndef SYNTHESIS
`define CAU_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
        else $error("assertion failed");
`define CAU_NEVER(lbl, expr) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) !(expr)) \
        else $error("forbidden condition");
`else
`define CAU_ASSERT(lbl, prop)
`define CAU_NEVER(lbl, expr)
`endif
`endif

// ===== rtl/cau_pkg.sv =====
// ----------------------------------------------------------------------------
// cau_pkg
// shared types and constants of the complex alu
// ----------------------------------------------------------------------------
package cau_pkg;

    localparam int WORD_BITS_DEF  = 32;
    localparam int FRAC_BITS_DEF  = 16;
    localparam int QUEUE_DEPTH    = 4;

    typedef enum logic [2:0] {
        OP_ADD = 3'd0,
        OP_SUB = 3'd1,
        OP_MUL = 3'd2,
        OP_DIV = 3'd3,
        OP_NEG = 3'd4,
        OP_INC = 3'd5,
        OP_DEC = 3'd6,
        OP_CMP = 3'd7
    } t_op;

    typedef enum logic [1:0] {
        K_SIMPLE = 2'd0,
        K_MUL    = 2'd1,
        K_DIV    = 2'd2
    } t_kind;

    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_SAT  = 2'd1;
    localparam logic [1:0] ST_DIV0 = 2'd2;

    typedef struct packed {
        t_kind      kind;
        logic       eq;
        logic       ne;
        logic [1:0] status;
    } t_ctrl;

endpackage

// ===== rtl/complex_arithmetic_unit_top.sv =====
// ----------------------------------------------------------------------------
// complex_arithmetic_unit_top
// throughput: one item per cycle while m_tready does not stall the output,
// set by the one-bit-per-stage divider pipeline
// a four-entry queue lets input transfers continue while the output stalls
// reset: synchronous active-low i_rst_n empties the queue and all stages
// ----------------------------------------------------------------------------
`include "complex_arithmetic_unit_top_defines.svh"

module complex_arithmetic_unit_top import cau_pkg::*; #(
    parameter int WORD_BITS = WORD_BITS_DEF,
    parameter int FRAC_BITS = FRAC_BITS_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                s_tvalid,
    output logic                s_tready,
    // a_real, a_imag, b_real, b_imag
    input  logic [((4*WORD_BITS+7)/8)*8-1:0] s_tdata,
    // operation
    input  logic [2:0]          s_tuser,
    output logic                m_tvalid,
    input  logic                m_tready,
    // res_real, res_imag, is_equal, not_equal, status
    output logic [((2*WORD_BITS+4+7)/8)*8-1:0] m_tdata
);

    localparam int W      = WORD_BITS;
    localparam int OBITS  = ((2*W+4+7)/8)*8;
    localparam int CBITS  = $bits(t_ctrl);
    localparam int QBITS  = 6*W + CBITS;

    t_ctrl        f_ctrl, q_ctrl, b_ctrl;
    logic [W-1:0] f_rr, f_ri, q_rr, q_ri, q_ar, q_ai, q_br, q_bi, b_rr, b_ri;
    logic [QBITS-1:0] q_din, q_dout;
    logic         q_full, q_empty, push, pop, en;

    cau_front #(.W(W), .F(FRAC_BITS)) u_front (
        .i_op   (s_tuser),
        .i_ar   (s_tdata[W-1:0]),
        .i_ai   (s_tdata[2*W-1:W]),
        .i_br   (s_tdata[3*W-1:2*W]),
        .i_bi   (s_tdata[4*W-1:3*W]),
        .o_ctrl (f_ctrl),
        .o_rr   (f_rr),
        .o_ri   (f_ri)
    );

    assign s_tready = !q_full;
    assign push     = s_tvalid && s_tready;
    assign q_din    = {f_ctrl, f_ri, f_rr, s_tdata[4*W-1:0]};

    cau_queue #(.BITS(QBITS), .DEPTH(QUEUE_DEPTH)) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (q_din),
        .i_pop   (pop),
        .o_data  (q_dout),
        .o_full  (q_full),
        .o_empty (q_empty)
    );

    assign {q_ctrl, q_ri, q_rr, q_bi, q_br, q_ai, q_ar} = q_dout;
    assign en  = !m_tvalid || m_tready;
    assign pop = en && !q_empty;

    cau_back #(.W(W), .F(FRAC_BITS)) u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (pop),
        .i_ctrl  (q_ctrl),
        .i_ar    (q_ar),
        .i_ai    (q_ai),
        .i_br    (q_br),
        .i_bi    (q_bi),
        .i_rr    (q_rr),
        .i_ri    (q_ri),
        .o_valid (m_tvalid),
        .o_ctrl  (b_ctrl),
        .o_rr    (b_rr),
        .o_ri    (b_ri)
    );

    assign m_tdata = OBITS'({b_ctrl.status, b_ctrl.ne, b_ctrl.eq, b_ri, b_rr});

    `CAU_ASSERT(a_flags_exclusive, m_tvalid |-> (b_ctrl.eq != b_ctrl.ne))
    `CAU_ASSERT(a_div0_zero, (m_tvalid && b_ctrl.status == ST_DIV0) |-> (b_rr == '0 && b_ri == '0))
    `CAU_NEVER(a_pop_empty, pop && q_empty)
    `CAU_ASSERT(a_full_blocks, q_full |-> !push)

endmodule

// ===== rtl/cau_front.sv =====
// ----------------------------------------------------------------------------
// cau_front
// classifies an item and finishes the simple operations
// ----------------------------------------------------------------------------
module cau_front import cau_pkg::*; #(
    parameter int W = WORD_BITS_DEF,
    parameter int F = FRAC_BITS_DEF
) (
    input  logic [2:0]          i_op,
    input  logic signed [W-1:0] i_ar,
    input  logic signed [W-1:0] i_ai,
    input  logic signed [W-1:0] i_br,
    input  logic signed [W-1:0] i_bi,
    output t_ctrl               o_ctrl,
    output logic [W-1:0]        o_rr,
    output logic [W-1:0]        o_ri
);

    function automatic logic [W:0] clamp_s(input logic signed [W+1:0] v);
        logic signed [W+1:0] maxv;
        logic signed [W+1:0] minv;
        maxv = {3'b000, {(W-1){1'b1}}};
        minv = {3'b111, {(W-1){1'b0}}};
        if (v > maxv) begin
            return {1'b1, maxv[W-1:0]};
        end else if (v < minv) begin
            return {1'b1, minv[W-1:0]};
        end
        return {1'b0, v[W-1:0]};
    endfunction

    logic signed [W+1:0] ar_x, ai_x, br_x, bi_x, one_x, x, y;
    logic [W:0]          cx, cy;

    always_comb begin
        ar_x  = (W+2)'(i_ar);
        ai_x  = (W+2)'(i_ai);
        br_x  = (W+2)'(i_br);
        bi_x  = (W+2)'(i_bi);
        one_x = (W+2)'(1) <<< F;
        x = '0;
        y = '0;
        o_ctrl.kind = K_SIMPLE;
        case (t_op'(i_op))
            OP_ADD: begin
                x = ar_x + br_x;
                y = ai_x + bi_x;
            end
            OP_SUB: begin
                x = ar_x - br_x;
                y = ai_x - bi_x;
            end
            OP_MUL: o_ctrl.kind = K_MUL;
            OP_DIV: o_ctrl.kind = K_DIV;
            OP_NEG: begin
                x = -ar_x;
                y = -ai_x;
            end
            OP_INC: begin
                x = ar_x + one_x;
                y = ai_x + one_x;
            end
            OP_DEC: begin
                x = ar_x - one_x;
                y = ai_x - one_x;
            end
            default: ;
        endcase
        cx = clamp_s(x);
        cy = clamp_s(y);
        o_rr = cx[W-1:0];
        o_ri = cy[W-1:0];
        o_ctrl.eq = (i_ar == i_br) && (i_ai == i_bi);
        o_ctrl.ne = (i_ar != i_br) || (i_ai != i_bi);
        o_ctrl.status = (o_ctrl.kind == K_SIMPLE && (cx[W] || cy[W])) ? ST_SAT : ST_OK;
    end

endmodule

// ===== rtl/cau_queue.sv =====
// ----------------------------------------------------------------------------
// cau_queue
// short fifo between the classifying front and the arithmetic back
// ----------------------------------------------------------------------------
module cau_queue import cau_pkg::*; #(
    parameter int BITS  = 8,
    parameter int DEPTH = QUEUE_DEPTH
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  logic [BITS-1:0] i_data,
    input  logic            i_pop,
    output logic [BITS-1:0] o_data,
    output logic            o_full,
    output logic            o_empty
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [BITS-1:0] r_mem [DEPTH];
    logic [AW-1:0]   r_wp, r_rp;
    logic [CW-1:0]   r_cnt;

    function automatic logic [AW-1:0] inc_ptr(input logic [AW-1:0] p);
        return (p == AW'(DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wp <= inc_ptr(r_wp);
            end
            if (i_pop) begin
                r_rp <= inc_ptr(r_rp);
            end
            r_cnt <= r_cnt + CW'(i_push) - CW'(i_pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_data;
        end
    end

    assign o_data  = r_mem[r_rp];
    assign o_full  = (r_cnt == CW'(DEPTH));
    assign o_empty = (r_cnt == '0);

endmodule

// ===== rtl/cau_back.sv =====
// ----------------------------------------------------------------------------
// cau_back
// pipelined multiply and restoring divide with final saturation
// ----------------------------------------------------------------------------
module cau_back import cau_pkg::*; #(
    parameter int W = WORD_BITS_DEF,
    parameter int F = FRAC_BITS_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_en,
    input  logic               i_valid,
    input  t_ctrl              i_ctrl,
    input  logic signed [W-1:0] i_ar,
    input  logic signed [W-1:0] i_ai,
    input  logic signed [W-1:0] i_br,
    input  logic signed [W-1:0] i_bi,
    input  logic [W-1:0]       i_rr,
    input  logic [W-1:0]       i_ri,
    output logic               o_valid,
    output t_ctrl              o_ctrl,
    output logic [W-1:0]       o_rr,
    output logic [W-1:0]       o_ri
);

    localparam int PW = 2 * W;

    function automatic logic [W:0] clamp_l(input logic signed [PW:0] v);
        logic signed [PW:0] maxv;
        logic signed [PW:0] minv;
        maxv = {{(W+2){1'b0}}, {(W-1){1'b1}}};
        minv = {{(W+2){1'b1}}, {(W-1){1'b0}}};
        if (v > maxv) begin
            return {1'b1, maxv[W-1:0]};
        end else if (v < minv) begin
            return {1'b1, minv[W-1:0]};
        end
        return {1'b0, v[W-1:0]};
    endfunction

    function automatic logic [W:0] clamp_q(input logic neg, input logic [W-1:0] q,
                                           input logic ovf);
        logic [W-1:0] lim;
        lim = neg ? {1'b1, {(W-1){1'b0}}} : {1'b0, {(W-1){1'b1}}};
        if (ovf || q > lim) begin
            return {1'b1, lim};
        end
        return {1'b0, neg ? -q : q};
    endfunction

    // operand stage
    logic               r0_v;
    t_ctrl              r0_ctrl;
    logic signed [W-1:0] r0_ar, r0_ai, r0_br, r0_bi;
    logic [W-1:0]       r0_rr, r0_ri;

    // product stage
    logic               r1_v;
    t_ctrl              r1_ctrl;
    logic signed [PW-1:0] r1_prr, r1_pii, r1_pri, r1_pir, r1_pbb, r1_pcc;
    logic [W-1:0]       r1_rr, r1_ri;

    // sum stage
    logic               r2_v;
    t_ctrl              r2_ctrl;
    logic signed [PW:0] r2_x, r2_y;
    logic [PW-1:0]      r2_den;
    logic [W-1:0]       r2_rr, r2_ri;

    // divider stages, index 0 is the entry
    logic               r_dv   [W+1];
    t_ctrl              r_dctl [W+1];
    logic [W-1:0]       r_drr  [W+1];
    logic [W-1:0]       r_dri  [W+1];
    logic [PW-1:0]      r_dden [W+1];
    logic [PW-1:0]      r_rem  [W+1][2];
    logic [W-1:0]       r_low  [W+1][2];
    logic [W-1:0]       r_quo  [W+1][2];
    logic               r_neg  [W+1][2];
    logic               r_ovf  [W+1][2];

    logic               r_ov;
    t_ctrl              r_octl;
    logic [W-1:0]       r_orr, r_ori;

    logic signed [PW:0] n_x, n_y;
    logic [PW:0]        n_mag [2];
    logic [W:0]         n_cx, n_cy;
    t_ctrl              n_ctl3;
    logic [W:0]         n_qx, n_qy;
    t_ctrl              n_octl;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r0_v  <= 1'b0;
            r1_v  <= 1'b0;
            r2_v  <= 1'b0;
            r_dv[0] <= 1'b0;
            r_ov  <= 1'b0;
        end else if (i_en) begin
            r0_v  <= i_valid;
            r1_v  <= r0_v;
            r2_v  <= r1_v;
            r_dv[0] <= r2_v;
            r_ov  <= r_dv[W];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r0_ctrl <= i_ctrl;
            r0_ar   <= i_ar;
            r0_ai   <= i_ai;
            r0_br   <= i_br;
            r0_bi   <= i_bi;
            r0_rr   <= i_rr;
            r0_ri   <= i_ri;

            r1_ctrl <= r0_ctrl;
            r1_rr   <= r0_rr;
            r1_ri   <= r0_ri;
            r1_prr  <= r0_ar * r0_br;
            r1_pii  <= r0_ai * r0_bi;
            r1_pri  <= r0_ar * r0_bi;
            r1_pir  <= r0_ai * r0_br;
            r1_pbb  <= r0_br * r0_br;
            r1_pcc  <= r0_bi * r0_bi;

            r2_ctrl <= r1_ctrl;
            r2_rr   <= r1_rr;
            r2_ri   <= r1_ri;
            r2_x    <= (r1_ctrl.kind == K_MUL) ? (PW+1)'(r1_prr) - (PW+1)'(r1_pii)
                                               : (PW+1)'(r1_prr) + (PW+1)'(r1_pii);
            r2_y    <= (r1_ctrl.kind == K_MUL) ? (PW+1)'(r1_pri) + (PW+1)'(r1_pir)
                                               : (PW+1)'(r1_pir) - (PW+1)'(r1_pri);
            r2_den  <= PW'(r1_pbb) + PW'(r1_pcc);
        end
    end

    // prepare stage: finish multiply, set up division
    always_comb begin
        n_x = r2_x >>> F;
        n_y = r2_y >>> F;
        n_cx = clamp_l(n_x);
        n_cy = clamp_l(n_y);
        n_mag[0] = r2_x[PW] ? -r2_x : r2_x;
        n_mag[1] = r2_y[PW] ? -r2_y : r2_y;
        n_ctl3 = r2_ctrl;
        if (r2_ctrl.kind == K_MUL) begin
            n_ctl3.status = (n_cx[W] || n_cy[W]) ? ST_SAT : ST_OK;
        end else if (r2_ctrl.kind == K_DIV && r2_den == '0) begin
            n_ctl3.status = ST_DIV0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_dctl[0] <= n_ctl3;
            r_drr[0]  <= (r2_ctrl.kind == K_MUL) ? n_cx[W-1:0] : r2_rr;
            r_dri[0]  <= (r2_ctrl.kind == K_MUL) ? n_cy[W-1:0] : r2_ri;
            r_dden[0] <= r2_den;
            for (int p = 0; p < 2; p++) begin
                r_rem[0][p] <= PW'(n_mag[p][PW-1:0] >> (W - F));
                r_low[0][p] <= n_mag[p][W-1:0] << F;
                r_quo[0][p] <= '0;
                r_neg[0][p] <= (p == 0) ? r2_x[PW] : r2_y[PW];
                r_ovf[0][p] <= PW'(n_mag[p][PW-1:0] >> (W - F)) >= r2_den;
            end
        end
    end

    for (genvar g = 0; g < W; g++) begin : g_div
        logic [PW:0] n_t [2];
        logic        n_ge [2];

        always_comb begin
            for (int p = 0; p < 2; p++) begin
                n_t[p]  = {r_rem[g][p], r_low[g][p][W-1]};
                n_ge[p] = n_t[p] >= {1'b0, r_dden[g]};
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_dv[g+1] <= 1'b0;
            end else if (i_en) begin
                r_dv[g+1] <= r_dv[g];
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_dctl[g+1] <= r_dctl[g];
                r_drr[g+1]  <= r_drr[g];
                r_dri[g+1]  <= r_dri[g];
                r_dden[g+1] <= r_dden[g];
                for (int p = 0; p < 2; p++) begin
                    r_rem[g+1][p] <= n_ge[p] ? PW'(n_t[p] - {1'b0, r_dden[g]})
                                             : n_t[p][PW-1:0];
                    r_low[g+1][p] <= r_low[g][p] << 1;
                    r_quo[g+1][p] <= {r_quo[g][p][W-2:0], n_ge[p]};
                    r_neg[g+1][p] <= r_neg[g][p];
                    r_ovf[g+1][p] <= r_ovf[g][p];
                end
            end
        end
    end

    // output stage
    always_comb begin
        n_qx = clamp_q(r_neg[W][0], r_quo[W][0], r_ovf[W][0]);
        n_qy = clamp_q(r_neg[W][1], r_quo[W][1], r_ovf[W][1]);
        n_octl = r_dctl[W];
        if (r_dctl[W].kind == K_DIV && r_dctl[W].status != ST_DIV0) begin
            n_octl.status = (n_qx[W] || n_qy[W]) ? ST_SAT : ST_OK;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_octl <= n_octl;
            if (r_dctl[W].kind == K_DIV) begin
                r_orr <= (r_dctl[W].status == ST_DIV0) ? '0 : n_qx[W-1:0];
                r_ori <= (r_dctl[W].status == ST_DIV0) ? '0 : n_qy[W-1:0];
            end else begin
                r_orr <= r_drr[W];
                r_ori <= r_dri[W];
            end
        end
    end

    assign o_valid = r_ov;
    assign o_ctrl  = r_octl;
    assign o_rr    = r_orr;
    assign o_ri    = r_ori;

endmodule

// ===== tb/complex_alu_checker.sv =====
// ----------------------------------------------------------------------------
// complex_alu_checker
// watches both stream channels of the complex alu, computes the expected
// result of every input transfer and compares each output transfer with it
// ----------------------------------------------------------------------------
module complex_alu_checker import cau_pkg::*; (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         s_tvalid,
    input  logic         s_tready,
    input  logic [127:0] s_tdata,
    input  logic [2:0]   s_tuser,
    input  logic         m_tvalid,
    input  logic         m_tready,
    input  logic [71:0]  m_tdata,
    output int           o_errors,
    output int           o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [1:0]  status;
        logic        ne;
        logic        eq;
        logic [31:0] im;
        logic [31:0] re;
    } t_res;

    t_res results_due[$];

    function automatic logic [31:0] clamp(input logic signed [127:0] v, inout logic sat);
        if (v > 128'sd2147483647) begin
            sat = 1'b1;
            return 32'h7fffffff;
        end
        if (v < -128'sd2147483648) begin
            sat = 1'b1;
            return 32'h80000000;
        end
        return v[31:0];
    endfunction

    function automatic t_res alu_result(input t_op op, input logic [127:0] d);
        logic signed [127:0] ar, ai, br, bi, one, den, nr, ni, qr, qi;
        logic sat;
        t_res r;
        ar = $signed(d[31:0]);
        ai = $signed(d[63:32]);
        br = $signed(d[95:64]);
        bi = $signed(d[127:96]);
        one = 128'sd65536;
        sat = 1'b0;
        r = '0;
        r.status = ST_OK;
        case (op)
            OP_ADD: begin
                r.re = clamp(ar + br, sat);
                r.im = clamp(ai + bi, sat);
            end
            OP_SUB: begin
                r.re = clamp(ar - br, sat);
                r.im = clamp(ai - bi, sat);
            end
            OP_MUL: begin
                r.re = clamp((ar * br - ai * bi) >>> 16, sat);
                r.im = clamp((ar * bi + ai * br) >>> 16, sat);
            end
            OP_DIV: begin
                den = br * br + bi * bi;
                if (den == 0) begin
                    r.status = ST_DIV0;
                end else begin
                    nr = (ar * br + ai * bi) <<< 16;
                    ni = (ai * br - ar * bi) <<< 16;
                    qr = nr / den;
                    qi = ni / den;
                    r.re = clamp(qr, sat);
                    r.im = clamp(qi, sat);
                end
            end
            OP_NEG: begin
                r.re = clamp(-ar, sat);
                r.im = clamp(-ai, sat);
            end
            OP_INC: begin
                r.re = clamp(ar + one, sat);
                r.im = clamp(ai + one, sat);
            end
            OP_DEC: begin
                r.re = clamp(ar - one, sat);
                r.im = clamp(ai - one, sat);
            end
            default: ;
        endcase
        if (r.status == ST_OK && sat) r.status = ST_SAT;
        r.eq = (ar == br) && (ai == bi);
        r.ne = (ar != br) || (ai != bi);
        return r;
    endfunction

    assign o_pending = results_due.size();

    always @(posedge i_clk) begin
        t_res got, want;
        if (!i_rst_n) begin
            o_errors <= 0;
        end else begin
            if (m_tvalid && m_tready) begin
                got = m_tdata[67:0];
                if (results_due.size() == 0) begin
                    $display("%0t unexpected transfer: got %h", $realtime, got);
                    o_errors <= o_errors + 1;
                end else begin
                    want = results_due.pop_front();
                    if (got !== want || m_tdata[71:68] !== 4'd0) begin
                        $display("%0t mismatch: expected re %h im %h eq %b ne %b st %0d,",
                                 $realtime, want.re, want.im, want.eq, want.ne,
                                 want.status);
                        $display("    actual re %h im %h eq %b ne %b st %0d",
                                 got.re, got.im, got.eq, got.ne, got.status);
                        o_errors <= o_errors + 1;
                    end
                end
            end
            if (s_tvalid && s_tready) begin
                results_due.push_back(alu_result(t_op'(s_tuser), s_tdata));
            end
        end
    end
endmodule

// ===== tb/tb_complex_arithmetic_unit_top.sv =====
// ----------------------------------------------------------------------------
// tb_complex_arithmetic_unit_top
// drives directed and random complex operand pairs through the alu under
// several idle and stall patterns; the checker judges every result
// ----------------------------------------------------------------------------
module tb_complex_arithmetic_unit_top import cau_pkg::*;;
    timeunit 1ns;
    timeprecision 1ps;

    logic         i_clk;
    logic         i_rst_n;
    logic         s_tvalid;
    logic         s_tready;
    logic [127:0] s_tdata;
    logic [2:0]   s_tuser;
    logic         m_tvalid;
    logic         m_tready;
    logic [71:0]  m_tdata;
    int           errors;
    int           pending;
    int           send_idle_pct;
    int           recv_stall_pct;
    int           quiet_cycles;

    complex_arithmetic_unit_top dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
    );

    complex_alu_checker checker_i (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .o_errors(errors), .o_pending(pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    always @(negedge i_clk) m_tready <= ($urandom_range(99) >= recv_stall_pct);

    always @(posedge i_clk) begin
        if (!i_rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready)) quiet_cycles <= 0;
        else quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles > 5000) begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    task automatic send_item(input t_op op, input logic [31:0] ar, input logic [31:0] ai,
                             input logic [31:0] br, input logic [31:0] bi);
        if ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(negedge i_clk);
            while ($urandom_range(99) < send_idle_pct) @(negedge i_clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {bi, br, ai, ar};
        @(posedge i_clk);
        while (!s_tready) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    function automatic logic [31:0] pick_word();
        case ($urandom_range(7))
            0: return 32'h7fffffff;
            1: return 32'h80000000;
            2: return 32'h0;
            3: return $urandom_range(131072) - 65536;
            4: return {{16{$urandom_range(1) == 1}}, 16'($urandom)};
            default: return $urandom;
        endcase
    endfunction

    initial begin
        logic [31:0] ar, ai, br, bi;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tuser = OP_ADD;
        m_tready = 1'b0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        i_rst_n = 1'b0;
        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        for (int k = 0; k < 8; k++) begin
            send_item(t_op'(k), 32'h7fffffff, 32'h80000000, 32'h7fffffff, 32'h80000000);
            send_item(t_op'(k), 32'h80000000, 32'h7fffffff, 32'h00010000, 32'hffff0000);
        end
        send_item(OP_DIV, 32'h00030000, 32'h1, 32'h0, 32'h0);
        send_item(OP_DIV, 32'h80000000, 32'h80000000, 32'h0, 32'h1);
        send_item(OP_DIV, 32'h7fffffff, 32'h7fffffff, 32'h80000000, 32'h80000000);
        send_item(OP_MUL, 32'hffffffff, 32'h0, 32'h1, 32'h0);
        send_item(OP_MUL, 32'h80000000, 32'h80000000, 32'h80000000, 32'h80000000);
        send_item(OP_ADD, 32'h00020000, 32'h5, 32'h00020000, 32'h6);
        for (int ph = 0; ph < 5; ph++) begin
            case (ph)
                1: begin send_idle_pct = 68; recv_stall_pct = 0; end
                2: begin send_idle_pct = 0; recv_stall_pct = 68; end
                3: begin send_idle_pct = 10; recv_stall_pct = 10; end
                default: begin send_idle_pct = 0; recv_stall_pct = 0; end
            endcase
            for (int n = 0; n < 350; n++) begin
                ar = pick_word();
                ai = pick_word();
                br = ($urandom_range(9) == 0) ? ar : pick_word();
                bi = ($urandom_range(9) == 0) ? ai : pick_word();
                if ($urandom_range(19) == 0) begin
                    br = 0;
                    bi = 0;
                end
                send_item(t_op'($urandom_range(7)), ar, ai, br, bi);
            end
        end
        s_tvalid <= 1'b0;
        recv_stall_pct = 0;
        while (pending != 0) @(posedge i_clk);
        repeat (60) @(posedge i_clk);
        if (errors == 0) $display("RESULT: OK");
        else $display("RESULT: ERROR");
        $finish;
    end
endmodule

// ===== files.f =====
+incdir+rtl
rtl/cau_pkg.sv
rtl/cau_front.sv
rtl/cau_queue.sv
rtl/cau_back.sv
rtl/complex_arithmetic_unit_top.sv
tb/complex_alu_checker.sv
tb/tb_complex_arithmetic_unit_top.sv
